// ===== sv/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// Types, constants and the CRC-8 byte update for the humidity/temperature
// frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;
   typedef logic [1:0]  status_type;
   typedef logic [2:0]  pos_type;

   localparam byte_type CRC_INIT = 8'hFF;
   localparam byte_type CRC_POLY = 8'h31;

   localparam logic [14:0] T_SCALE    = 15'd21875;
   localparam logic [13:0] H_SCALE    = 14'd12500;
   localparam int          CONV_SHIFT = 13;
   localparam logic [17:0] T_OFFSET   = 18'd45000;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_T_CRC   = 2'd1;
   localparam status_type STATUS_H_CRC   = 2'd2;

   localparam pos_type POS_T_MSB = 3'd0;
   localparam pos_type POS_T_LSB = 3'd1;
   localparam pos_type POS_T_CRC = 3'd2;
   localparam pos_type POS_H_MSB = 3'd3;
   localparam pos_type POS_H_LSB = 3'd4;
   localparam pos_type POS_H_CRC = 3'd5;

   localparam int RSP_DATA_W = 72;

   function automatic byte_type crc8_update(input byte_type crc, input byte_type b);
      byte_type c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/humidity_temp_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core
// Decodes six-byte sensor read frames (temperature word, CRC-8, humidity
// word, CRC-8) into raw words, converted values and a CRC status.
// ----------------------------------------------------------------------------
// One request carries one frame byte; a request is accepted every cycle
// while the result side keeps up. The CRC-8 (poly 0x31, init 0xFF) is
// updated as each data byte is accepted. The sixth byte moves the frame into
// a holding stage, and the next stage does the two constant multiplies and
// registers the result.
// frame_start on any byte drops a partial frame and restarts at byte 0.
// Status 1 flags a temperature CRC error, status 2 a humidity CRC error;
// the converted values are then zero while the raw words are still given.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  htfd_pkg::byte_type        req_tdata,   // [7:0] rx_byte
   input  logic                      req_tuser,   // [0] frame_start
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [htfd_pkg::RSP_DATA_W-1:0] rsp_tdata, // [17:0] temperature_milli,
                                                  // [34:18] humidity_milli,
                                                  // [50:35] raw_temperature,
                                                  // [66:51] raw_humidity,
                                                  // [71:67] zero
   output htfd_pkg::status_type      rsp_tuser    // [1:0] frame_status
);
   import htfd_pkg::*;

   logic       req_acc;
   logic       out_en;

   pos_type    pos_ff, pos_in, pos_cur;
   byte_type   crc_ff, crc_in, crc_cur, crc_next;
   byte_type   hold_ff, hold_in;
   word_type   tword_ff, tword_in;
   word_type   hword_ff, hword_in;
   logic       tgood_ff, tgood_in;

   logic       s1_vld_ff, s1_vld_in;
   word_type   s1_tword_ff, s1_tword_in;
   word_type   s1_hword_ff, s1_hword_in;
   status_type s1_status_ff, s1_status_in;

   logic       out_vld_ff, out_vld_in;
   logic [17:0] out_t_ff, out_t_in;
   logic [16:0] out_h_ff, out_h_in;
   word_type   out_tword_ff, out_tword_in;
   word_type   out_hword_ff, out_hword_in;
   status_type out_status_ff, out_status_in;

   logic [30:0] t_prod;
   logic [29:0] h_prod;

   assign out_en     = !out_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || out_en;
   assign req_acc    = req_tvalid && req_tready;

   assign pos_cur  = req_tuser ? POS_T_MSB : pos_ff;
   assign crc_cur  = req_tuser ? CRC_INIT : crc_ff;
   assign crc_next = crc8_update(crc_cur, req_tdata);

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      hold_in      = hold_ff;
      tword_in     = tword_ff;
      hword_in     = hword_ff;
      tgood_in     = tgood_ff;
      s1_tword_in  = s1_tword_ff;
      s1_hword_in  = s1_hword_ff;
      s1_status_in = s1_status_ff;
      s1_vld_in    = s1_vld_ff && !out_en;
      if (req_acc) begin
         case (pos_cur)
            POS_T_MSB, POS_H_MSB: begin
               crc_in  = crc_next;
               hold_in = req_tdata;
               pos_in  = pos_cur + 3'd1;
            end
            POS_T_LSB: begin
               crc_in   = crc_next;
               tword_in = {hold_ff, req_tdata};
               pos_in   = POS_T_CRC;
            end
            POS_T_CRC: begin
               tgood_in = (crc_cur == req_tdata);
               crc_in   = CRC_INIT;
               pos_in   = POS_H_MSB;
            end
            POS_H_LSB: begin
               crc_in   = crc_next;
               hword_in = {hold_ff, req_tdata};
               pos_in   = POS_H_CRC;
            end
            default: begin
               if (!tgood_ff) begin
                  s1_status_in = STATUS_T_CRC;
               end else if (crc_cur != req_tdata) begin
                  s1_status_in = STATUS_H_CRC;
               end else begin
                  s1_status_in = STATUS_OK;
               end
               s1_tword_in = tword_ff;
               s1_hword_in = hword_ff;
               s1_vld_in   = 1'b1;
               pos_in      = POS_T_MSB;
               crc_in      = CRC_INIT;
               tgood_in    = 1'b0;
            end
         endcase
      end
   end

   assign t_prod = 31'(s1_tword_ff) * 31'(T_SCALE);
   assign h_prod = 30'(s1_hword_ff) * 30'(H_SCALE);

   always_comb begin
      out_vld_in    = out_vld_ff && !rsp_tready;
      out_t_in      = out_t_ff;
      out_h_in      = out_h_ff;
      out_tword_in  = out_tword_ff;
      out_hword_in  = out_hword_ff;
      out_status_in = out_status_ff;
      if (out_en && s1_vld_ff) begin
         out_vld_in    = 1'b1;
         out_tword_in  = s1_tword_ff;
         out_hword_in  = s1_hword_ff;
         out_status_in = s1_status_ff;
         if (s1_status_ff == STATUS_OK) begin
            out_t_in = t_prod[CONV_SHIFT +: 18] - T_OFFSET;
            out_h_in = h_prod[CONV_SHIFT +: 17];
         end else begin
            out_t_in = '0;
            out_h_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_T_MSB;
         crc_ff     <= CRC_INIT;
         tgood_ff   <= 1'b0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         tgood_ff   <= tgood_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff       <= hold_in;
      tword_ff      <= tword_in;
      hword_ff      <= hword_in;
      s1_tword_ff   <= s1_tword_in;
      s1_hword_ff   <= s1_hword_in;
      s1_status_ff  <= s1_status_in;
      out_t_ff      <= out_t_in;
      out_h_ff      <= out_h_in;
      out_tword_ff  <= out_tword_in;
      out_hword_ff  <= out_hword_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'b0, out_hword_ff, out_tword_ff, out_h_ff, out_t_ff};
   assign rsp_tuser  = out_status_ff;

endmodule
